// File: rtl/core/gfbr_pkg.sv
// gfbr_pkg: shared types and codes for the gap-framed byte ring
// holds the transaction structs, command classes and result status codes
// no dependencies
`timescale 1ns / 1ps

package gfbr_pkg;

	localparam int LEN_W = 10;
	localparam logic [LEN_W-1:0] OPEN_MAX = 10'd1023;

	// raw mode codes on the input port
	localparam logic [1:0] MODE_RX   = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	typedef enum logic [1:0] {
		OP_RX   = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_BYTE      = 3'd1,
		ST_NO_FRAME  = 3'd2,
		ST_CAP_SHORT = 3'd3,
		ST_FLUSHED   = 3'd4,
		ST_DROPPED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  rx_byte;
		logic [15:0] read_capacity;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       data_byte;
		logic             last_byte;
		logic [LEN_W-1:0] head_frame_length;
		logic [2:0]       frames_waiting;
		logic             frame_closed;
		logic [31:0]      queue_overflows;
		logic [31:0]      bytes_received;
	} result_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t         op;
		logic [7:0]  rx_byte;
		logic [15:0] read_capacity;
	} cmd_t;

endpackage

// File: rtl/core/gfbr_front.sv
// gfbr_front: accepts transactions, classifies the mode and queues commands
// two-entry command queue towards the back end; depends on gfbr_pkg
`timescale 1ns / 1ps

module gfbr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gfbr_pkg::in_item_t item,
	output logic               busy,
	output logic               cmd_valid,
	output gfbr_pkg::cmd_t     cmd,
	input  logic               cmd_take
);
	import gfbr_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	cmd_t       cls;

	always_comb begin
		cls.rx_byte       = item.rx_byte;
		cls.read_capacity = item.read_capacity;
		unique case (item.mode)
			MODE_RX:   cls.op = OP_RX;
			MODE_TICK: cls.op = OP_TICK;
			MODE_READ: cls.op = OP_READ;
			default:   cls.op = OP_NOP;
		endcase
	end

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/core/gfbr_back.sv
// gfbr_back: carries out commands on the byte ring, length queue and gap timer
// owns the ring memory, the length memory and the result register; depends on gfbr_pkg
`timescale 1ns / 1ps

module gfbr_back #(
	parameter int RING_DEPTH  = 512,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              cmd_valid,
	input  gfbr_pkg::cmd_t    cmd,
	output logic              cmd_take,
	output logic              done,
	output gfbr_pkg::result_t result
);
	import gfbr_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int LW = (CW > LEN_W) ? CW : LEN_W;

	logic [7:0]       ring_mem [RING_DEPTH];
	logic [LEN_W-1:0] lq_mem   [QUEUE_DEPTH];

	logic [AW-1:0]    wp_q, rp_q, wp_d, rp_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [QW-1:0]    head_q, tail_q, head_d, tail_d;
	logic [LEN_W-1:0] open_len_q, open_len_d;
	logic             open_good_q, open_good_d;
	logic             tmr_run_q, tmr_run_d;
	logic [15:0]      tmr_cnt_q, tmr_cnt_d, tmr_inc;
	logic [LEN_W-1:0] rd_off_q, rd_off_d, rd_off_inc;
	logic [31:0]      ovf_q, ovf_d;
	logic [31:0]      rx_q, rx_d;
	logic [15:0]      gap_q;

	logic             done_s1;
	status_t          status_s1, status_d;
	logic             deliver_s1, deliver_d;
	logic             last_s1, last_d;
	logic             closed_s1, closed_d;
	logic [7:0]       ring_rd_s1;
	logic [LEN_W-1:0] len_rd_q;

	logic             ring_we, lq_we;
	logic [AW-1:0]    wp_nx, rp_nx;
	logic [QW-1:0]    head_nx, tail_nx;
	logic [LW-1:0]    cnt_w, len_w;
	logic             q_empty;
	logic [QW:0]      wait_n;
	logic [QW+2:0]    wait_x;

	assign cmd_take = 1'b1;

	assign wp_nx   = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_nx   = (rp_q == AW'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign head_nx = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign cnt_w   = LW'(cnt_q);
	assign len_w   = LW'(len_rd_q);
	assign q_empty = (head_q == tail_q);
	assign tmr_inc = tmr_cnt_q + 16'd1;

	always_comb begin
		wp_d        = wp_q;
		rp_d        = rp_q;
		cnt_d       = cnt_q;
		head_d      = head_q;
		tail_d      = tail_q;
		open_len_d  = open_len_q;
		open_good_d = open_good_q;
		tmr_run_d   = tmr_run_q;
		tmr_cnt_d   = tmr_cnt_q;
		rd_off_d    = rd_off_q;
		rd_off_inc  = rd_off_q;
		ovf_d       = ovf_q;
		rx_d        = rx_q;
		status_d    = ST_DONE;
		deliver_d   = 1'b0;
		last_d      = 1'b0;
		closed_d    = 1'b0;
		ring_we     = 1'b0;
		lq_we       = 1'b0;
		if (cmd_valid) begin
			unique case (cmd.op)
				OP_RX: begin
					rx_d = rx_q + 32'd1;
					if (cnt_q < CW'(RING_DEPTH)) begin
						ring_we = 1'b1;
						wp_d    = wp_nx;
						cnt_d   = cnt_q + 1'b1;
						if (open_len_q < OPEN_MAX) begin
							open_len_d = open_len_q + 1'b1;
						end
					end else begin
						open_good_d = 1'b0;
						status_d    = ST_DROPPED;
					end
					tmr_run_d = 1'b1;
					tmr_cnt_d = '0;
				end
				OP_TICK: begin
					if (tmr_run_q) begin
						tmr_cnt_d = tmr_inc;
						if (tmr_inc >= gap_q) begin
							tmr_run_d = 1'b0;
							tmr_cnt_d = '0;
							closed_d  = 1'b1;
							if (open_len_q != '0) begin
								// a good frame is queued unless the queue is full
								if (open_good_q && (head_nx != tail_q)) begin
									lq_we  = 1'b1;
									head_d = head_nx;
								end else begin
									if (open_good_q) begin
										ovf_d = ovf_q + 32'd1;
									end
									wp_d     = '0;
									rp_d     = '0;
									cnt_d    = '0;
									head_d   = '0;
									tail_d   = '0;
									rd_off_d = '0;
								end
							end
							open_len_d  = '0;
							open_good_d = 1'b1;
						end
					end
				end
				OP_READ: begin
					if (q_empty) begin
						rd_off_d = '0;
						status_d = ST_NO_FRAME;
					end else if ((rd_off_q == '0) &&
							(cmd.read_capacity < 16'(len_rd_q))) begin
						status_d = ST_CAP_SHORT;
					end else if (((rd_off_q == '0) && (cnt_w < len_w)) ||
							((rd_off_q != '0) && (cnt_q == '0))) begin
						wp_d     = '0;
						rp_d     = '0;
						cnt_d    = '0;
						head_d   = '0;
						tail_d   = '0;
						rd_off_d = '0;
						status_d = ST_FLUSHED;
					end else begin
						status_d = ST_BYTE;
						if ((len_rd_q != '0) && (cnt_q != '0)) begin
							deliver_d  = 1'b1;
							rp_d       = rp_nx;
							cnt_d      = cnt_q - 1'b1;
							rd_off_inc = rd_off_q + 1'b1;
						end
						rd_off_d = rd_off_inc;
						if (rd_off_inc >= len_rd_q) begin
							last_d   = 1'b1;
							rd_off_d = '0;
							tail_d   = tail_nx;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ring write and registered read at the current read pointer
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wp_q] <= cmd.rx_byte;
		end
		ring_rd_s1 <= ring_mem[rp_q];
	end

	// length memory read at the next tail, with bypass of a write to that entry
	always_ff @(posedge clk) begin
		if (lq_we) begin
			lq_mem[head_q] <= open_len_q;
		end
		if (lq_we && (head_q == tail_d)) begin
			len_rd_q <= open_len_q;
		end else begin
			len_rd_q <= lq_mem[tail_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			open_len_q  <= '0;
			open_good_q <= 1'b1;
			tmr_run_q   <= 1'b0;
			tmr_cnt_q   <= '0;
			rd_off_q    <= '0;
			ovf_q       <= '0;
			rx_q        <= '0;
			gap_q       <= 16'd4100;
			done_s1     <= 1'b0;
			status_s1   <= ST_DONE;
			deliver_s1  <= 1'b0;
			last_s1     <= 1'b0;
			closed_s1   <= 1'b0;
		end else begin
			wp_q        <= wp_d;
			rp_q        <= rp_d;
			cnt_q       <= cnt_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			open_len_q  <= open_len_d;
			open_good_q <= open_good_d;
			tmr_run_q   <= tmr_run_d;
			tmr_cnt_q   <= tmr_cnt_d;
			rd_off_q    <= rd_off_d;
			ovf_q       <= ovf_d;
			rx_q        <= rx_d;
			if (cfg_we) begin
				gap_q <= cfg_wdata;
			end
			done_s1    <= cmd_valid;
			status_s1  <= status_d;
			deliver_s1 <= deliver_d;
			last_s1    <= last_d;
			closed_s1  <= closed_d;
		end
	end

	// state registers already hold the post-transaction values here
	always_comb begin
		if (head_q >= tail_q) begin
			wait_n = {1'b0, head_q} - {1'b0, tail_q};
		end else begin
			wait_n = {1'b0, head_q} + (QW+1)'(QUEUE_DEPTH) - {1'b0, tail_q};
		end
		wait_x = (QW+3)'(wait_n);
	end

	assign done = done_s1;

	always_comb begin
		result.status            = status_s1;
		result.data_byte         = deliver_s1 ? ring_rd_s1 : 8'd0;
		result.last_byte         = last_s1;
		result.head_frame_length = q_empty ? '0 : len_rd_q;
		result.frames_waiting    = wait_x[2:0];
		result.frame_closed      = closed_s1;
		result.queue_overflows   = ovf_q;
		result.bytes_received    = rx_q;
	end

endmodule

// File: rtl/core/gap_framed_byte_ring_unit.sv
// a taken start is held in the command queue; done is registered in the back end
// throughput: one transaction per cycle; the back end retires one command every cycle,
// so busy rises only if the two-entry command queue fills, which it does not
// reset: asynchronous, clears pointers, counters and timer, gap register to 4100;
// byte ring and length memory are not cleared and need no clearing pass
// top level of the gap-framed byte ring; depends on gfbr_pkg, gfbr_front, gfbr_back
`timescale 1ns / 1ps

module gap_framed_byte_ring_unit #(
	parameter int RING_DEPTH  = 512,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              start,
	output logic              busy,
	input  gfbr_pkg::in_item_t item,
	output logic              done,
	output gfbr_pkg::result_t result
);
	import gfbr_pkg::*;

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	gfbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	gfbr_back #(
		.RING_DEPTH  (RING_DEPTH),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.done      (done),
		.result    (result)
	);

endmodule
